### sv/sorted_alarm_queue_macros.svh
// Assertion macros shared by the checker file.
`ifndef SORTED_ALARM_QUEUE_MACROS_SVH
`define SORTED_ALARM_QUEUE_MACROS_SVH

// Clocked property, switched off while reset is held.
`define SAQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds through reset.
`define SAQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/saq_pkg.sv
package saq_pkg;

    localparam int DEPTH       = 8;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int MAX_RESULTS = 8;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    localparam logic [7:0] NIBBLE_MASK = 8'h0F;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    // commands
    localparam logic [1:0] CMD_ADD_TIME     = 2'd0;
    localparam logic [1:0] CMD_ADD_DATETIME = 2'd1;
    localparam logic [1:0] CMD_DELETE_TAG   = 2'd2;
    localparam logic [1:0] CMD_FIRE         = 2'd3;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [7:0] tag;
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } alarm_t;

    // sort key: month and year take no part
    function automatic logic [31:0] order_key(input alarm_t e);
        return {e.day, e.hour, e.minute, e.second};
    endfunction

    function automatic logic same_datetime(input alarm_t a, input alarm_t b);
        return (a.second == b.second) && (a.minute == b.minute) && (a.hour == b.hour) &&
               (a.day == b.day) && (a.month == b.month) && (a.year == b.year);
    endfunction

endpackage

### sv/sorted_alarm_queue.sv
// Time-ordered alarm queue, up to saq_pkg::DEPTH entries, kept in logical order
// with the head in entry 0.
// Input channel s_*: one transaction per command; s_tuser carries the command,
// s_tdata the alarm time/date, the current clock and the tag.
// Result channel m_*: one transaction per command, or one per popped alarm on
// fire; m_tlast marks the final result of a command, m_tuser flags a fired tag.
// Timing: each scan state steps through one entry a cycle; delete shifts out a
// matching entry in the step that finds it, insert opens its gap in the step
// that ends its scan, and fire shifts out its n popped alarms (n <= 8) one per
// emitted result. s_tready is high only while idle.
// Reset empties the queue and drops any pending result; stored entries keep
// stale contents but are never read before being written again.
// When the receiver stalls, the result register holds and the sequencer waits
// before producing the next result.
module sorted_alarm_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: alarm_second, alarm_minute, alarm_hour, alarm_day, alarm_month,
    //        alarm_year, now_hour, now_minute, now_second, tag
    input  logic [saq_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: cmd
    input  logic [saq_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata: event_tag, status, deleted_count, alarm_count, compare_hour,
    //        compare_minute, compare_second, compare_enable, zero pad
    output logic [saq_pkg::M_TDATA_W-1:0]  m_tdata,
    // tuser: event_valid
    output logic                           m_tuser,
    output logic                           m_tlast
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_SCAN  = 3'd1;
    localparam logic [2:0] S_DEL_SCAN  = 3'd2;
    localparam logic [2:0] S_FIRE_SCAN = 3'd3;
    localparam logic [2:0] S_FIRE_HEAD = 3'd4;
    localparam logic [2:0] S_FIRE_EMIT = 3'd5;
    localparam logic [2:0] S_FINISH    = 3'd6;

    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_INS  = 2'd1;
    localparam logic [1:0] SH_DEL  = 2'd2;

    localparam int CNT_W = saq_pkg::CNT_W;
    localparam int IDX_W = saq_pkg::IDX_W;

    function automatic logic [saq_pkg::M_TDATA_W-1:0] pack_result(
        input logic [7:0]  tag,
        input logic [1:0]  st,
        input logic [3:0]  del_cnt,
        input logic [3:0]  alarm_cnt,
        input logic [23:0] hms,
        input logic        cmp_en
    );
        return {5'b0, cmp_en, hms[7:0], hms[15:8], hms[23:16], alarm_cnt, del_cnt, st, tag};
    endfunction

    saq_pkg::alarm_t entry_reg [saq_pkg::DEPTH];

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0] del_n_reg, del_n_next;
    logic [1:0]       status_reg, status_next;
    saq_pkg::alarm_t  new_reg, new_next;
    logic [23:0]      fcmp_reg, fcmp_next;
    logic             fcmp_en_reg, fcmp_en_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [saq_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg, m_tuser_next;
    logic                          m_tlast_reg, m_tlast_next;

    logic [1:0]       sh_op;
    logic [IDX_W-1:0] sh_pos;

    saq_pkg::alarm_t in_e;
    saq_pkg::alarm_t rd;
    saq_pkg::alarm_t head;
    logic [23:0]     at_hms;
    logic [23:0]     now_hms;
    logic            out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign rd       = entry_reg[idx_reg[IDX_W-1:0]];
    assign head     = entry_reg[0];

    // unpack, roll the day for add_time, bump a zero second nibble
    assign at_hms  = {s_tdata[23:16], s_tdata[15:8], s_tdata[7:0]};
    assign now_hms = {s_tdata[55:48], s_tdata[63:56], s_tdata[71:64]};
    always_comb begin
        in_e.second = s_tdata[7:0];
        in_e.minute = s_tdata[15:8];
        in_e.hour   = s_tdata[23:16];
        in_e.day    = s_tdata[31:24];
        in_e.month  = s_tdata[39:32];
        in_e.year   = s_tdata[47:40];
        in_e.tag    = s_tdata[79:72];
        if (s_tuser == saq_pkg::CMD_ADD_TIME && at_hms <= now_hms) begin
            in_e.day = s_tdata[31:24] + 8'd1;
        end
        if ((s_tdata[7:0] & saq_pkg::NIBBLE_MASK) == 8'h00) begin
            in_e.second = s_tdata[7:0] + 8'd1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        left_next     = left_reg;
        del_n_next    = del_n_reg;
        status_next   = status_reg;
        new_next      = new_reg;
        fcmp_next     = fcmp_reg;
        fcmp_en_next  = fcmp_en_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        sh_op         = SH_NONE;
        sh_pos        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    new_next    = in_e;
                    idx_next    = '0;
                    del_n_next  = '0;
                    status_next = saq_pkg::ST_OK;
                    unique case (s_tuser)
                        saq_pkg::CMD_ADD_TIME, saq_pkg::CMD_ADD_DATETIME: begin
                            if (count_reg >= saq_pkg::DEPTH_CNT) begin
                                status_next = saq_pkg::ST_FULL;
                                state_next  = S_FINISH;
                            end else begin
                                state_next = S_INS_SCAN;
                            end
                        end
                        saq_pkg::CMD_DELETE_TAG: begin
                            state_next = S_DEL_SCAN;
                        end
                        saq_pkg::CMD_FIRE: begin
                            if (count_reg == '0) begin
                                status_next = saq_pkg::ST_EMPTY;
                                state_next  = S_FINISH;
                            end else begin
                                state_next = S_FIRE_SCAN;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_INS_SCAN: begin
                // new alarm goes after every entry that is not later
                if (idx_reg < count_reg &&
                    saq_pkg::order_key(rd) <= saq_pkg::order_key(new_reg)) begin
                    idx_next = idx_reg + 1'b1;
                end else begin
                    sh_op      = SH_INS;
                    sh_pos     = idx_reg[IDX_W-1:0];
                    count_next = count_reg + 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_DEL_SCAN: begin
                if (idx_reg < count_reg) begin
                    if (rd.tag == new_reg.tag) begin
                        sh_op      = SH_DEL;
                        sh_pos     = idx_reg[IDX_W-1:0];
                        count_next = count_reg - 1'b1;
                        del_n_next = del_n_reg + 1'b1;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FIRE_SCAN: begin
                if (idx_reg < count_reg && 32'(idx_reg) < saq_pkg::MAX_RESULTS &&
                    saq_pkg::same_datetime(head, rd)) begin
                    idx_next = idx_reg + 1'b1;
                end else begin
                    left_next  = idx_reg;
                    count_next = count_reg - idx_reg;
                    state_next = S_FIRE_HEAD;
                end
            end
            S_FIRE_HEAD: begin
                // rd points at the entry that becomes head once the run is popped
                if (count_reg != '0) begin
                    fcmp_next    = {rd.hour, rd.minute, rd.second};
                    fcmp_en_next = 1'b1;
                end else begin
                    fcmp_next    = '0;
                    fcmp_en_next = 1'b0;
                end
                state_next = S_FIRE_EMIT;
            end
            S_FIRE_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = (left_reg == CNT_W'(1));
                    m_tdata_next  = pack_result(head.tag, saq_pkg::ST_OK, 4'd0,
                                                4'(count_reg), fcmp_reg, fcmp_en_reg);
                    sh_op         = SH_DEL;
                    sh_pos        = '0;
                    left_next     = left_reg - 1'b1;
                    if (left_reg == CNT_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b0;
                    m_tlast_next  = 1'b1;
                    if (count_reg != '0) begin
                        m_tdata_next = pack_result(8'd0, status_reg, 4'(del_n_reg),
                                                   4'(count_reg),
                                                   {head.hour, head.minute, head.second},
                                                   1'b1);
                    end else begin
                        m_tdata_next = pack_result(8'd0, status_reg, 4'(del_n_reg),
                                                   4'(count_reg), 24'd0, 1'b0);
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        left_reg    <= left_next;
        del_n_reg   <= del_n_next;
        status_reg  <= status_next;
        new_reg     <= new_next;
        fcmp_reg    <= fcmp_next;
        fcmp_en_reg <= fcmp_en_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    // entry store: open a gap at sh_pos, or close one there
    always_ff @(posedge aclk) begin
        for (int k = 0; k < saq_pkg::DEPTH; k++) begin
            unique case (sh_op)
                SH_INS: begin
                    if (IDX_W'(k) > sh_pos) begin
                        entry_reg[k] <= entry_reg[IDX_W'(k - 1)];
                    end else if (IDX_W'(k) == sh_pos) begin
                        entry_reg[k] <= new_reg;
                    end
                end
                SH_DEL: begin
                    if (IDX_W'(k) >= sh_pos && k < saq_pkg::DEPTH - 1) begin
                        entry_reg[k] <= entry_reg[IDX_W'(k + 1)];
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### sv/saq_checker.sv
`include "sorted_alarm_queue_macros.svh"

module saq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [saq_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [saq_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [saq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);

    logic unused_in;
    assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata) ^ (^s_tuser);

    // no stale result survives reset
    `SAQ_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // a stalled result transaction holds
    `SAQ_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // compare_enable follows alarm_count
    `SAQ_ASSERT(a_cmp_en, aclk, aresetn, m_tvalid |-> (m_tdata[42] == (m_tdata[17:14] != 4'd0)), "compare_enable disagrees with alarm_count")

    // empty queue shows zero compare time
    `SAQ_ASSERT(a_cmp_zero, aclk, aresetn, m_tvalid && !m_tdata[42] |-> m_tdata[41:18] == 24'd0, "compare time not zero on empty queue")

    // fired tags carry no status and no delete count; other results close the command
    `SAQ_ASSERT(a_event_fields, aclk, aresetn, m_tvalid |-> (m_tuser ? (m_tdata[13:8] == 6'd0) : m_tlast), "result fields inconsistent with event flag")

endmodule

bind sorted_alarm_queue saq_checker u_saq_checker (.*);

### tb/sv/tb_sorted_alarm_queue.sv
`timescale 1ns / 1ps

module tb_sorted_alarm_queue;

    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        logic       event_valid;
        logic [7:0] event_tag;
        logic       last;
        logic [1:0] status;
        logic [3:0] deleted_count;
        logic [3:0] alarm_count;
        logic [7:0] compare_hour;
        logic [7:0] compare_minute;
        logic [7:0] compare_second;
        logic       compare_enable;
    } result_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [saq_pkg::S_TDATA_W-1:0] s_tdata;
    logic [saq_pkg::S_TUSER_W-1:0] s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [saq_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;

    saq_pkg::alarm_t held_alarms[$];      // mirror of the queue, head first
    result_t         expected_results[$];
    saq_pkg::alarm_t dt_pool[4];
    logic [7:0]      tag_pool[4];
    bit              gaps_on;
    int              error_count = 0;
    int              idle_cycles = 0;

    sorted_alarm_queue u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // mostly back-to-back, some short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic saq_pkg::alarm_t make_alarm(input logic [7:0] sec,
                                                   input logic [7:0] mins,
                                                   input logic [7:0] hr, input logic [7:0] dy,
                                                   input logic [7:0] mon, input logic [7:0] yr,
                                                   input logic [7:0] tg);
        saq_pkg::alarm_t a;
        a.second = sec;
        a.minute = mins;
        a.hour   = hr;
        a.day    = dy;
        a.month  = mon;
        a.year   = yr;
        a.tag    = tg;
        return a;
    endfunction

    // queues one expected result, taken against the queue state after the command
    function automatic void push_result(input logic ev, input logic [7:0] tg, input logic lst,
                                        input logic [1:0] st, input logic [3:0] deleted);
        result_t r;
        r.event_valid   = ev;
        r.event_tag     = tg;
        r.last          = lst;
        r.status        = st;
        r.deleted_count = deleted;
        r.alarm_count   = 4'(held_alarms.size());
        if (held_alarms.size() > 0) begin
            r.compare_hour   = held_alarms[0].hour;
            r.compare_minute = held_alarms[0].minute;
            r.compare_second = held_alarms[0].second;
            r.compare_enable = 1'b1;
        end else begin
            r.compare_hour   = 8'h00;
            r.compare_minute = 8'h00;
            r.compare_second = 8'h00;
            r.compare_enable = 1'b0;
        end
        expected_results.push_back(r);
    endfunction

    function automatic void predict_results(input logic [1:0] cmd, input saq_pkg::alarm_t a,
                                            input logic [7:0] nh, input logic [7:0] nm,
                                            input logic [7:0] ns);
        saq_pkg::alarm_t e;
        saq_pkg::alarm_t head;
        int              pos;
        int              n;
        logic [7:0]      fired[$];
        e = a;
        case (cmd)
            saq_pkg::CMD_ADD_TIME, saq_pkg::CMD_ADD_DATETIME: begin
                // alarm not later than now rolls on to the next day, raw byte wrap
                if (cmd == saq_pkg::CMD_ADD_TIME &&
                    {e.hour, e.minute, e.second} <= {nh, nm, ns})
                    e.day = e.day + 8'd1;
                if (held_alarms.size() >= saq_pkg::DEPTH) begin
                    push_result(1'b0, 8'h00, 1'b1, saq_pkg::ST_FULL, 4'd0);
                end else begin
                    if ((e.second & saq_pkg::NIBBLE_MASK) == 8'h00)
                        e.second = e.second + 8'd1;
                    pos = 0;
                    while (pos < held_alarms.size() &&
                           {held_alarms[pos].day, held_alarms[pos].hour,
                            held_alarms[pos].minute, held_alarms[pos].second} <=
                           {e.day, e.hour, e.minute, e.second})
                        pos++;
                    held_alarms.insert(pos, e);
                    push_result(1'b0, 8'h00, 1'b1, saq_pkg::ST_OK, 4'd0);
                end
            end
            saq_pkg::CMD_DELETE_TAG: begin
                pos = 0;
                n = 0;
                while (pos < held_alarms.size()) begin
                    if (held_alarms[pos].tag == e.tag) begin
                        held_alarms.delete(pos);
                        n++;
                    end else begin
                        pos++;
                    end
                end
                push_result(1'b0, 8'h00, 1'b1, saq_pkg::ST_OK, 4'(n));
            end
            default: begin
                if (held_alarms.size() == 0) begin
                    push_result(1'b0, 8'h00, 1'b1, saq_pkg::ST_EMPTY, 4'd0);
                end else begin
                    head = held_alarms[0];
                    n = 0;
                    // bits 47:0 hold the full datetime, the tag sits above
                    while (n < held_alarms.size() && n < saq_pkg::MAX_RESULTS &&
                           held_alarms[n][47:0] == head[47:0]) begin
                        fired.push_back(held_alarms[n].tag);
                        n++;
                    end
                    repeat (n) void'(held_alarms.pop_front());
                    for (int k = 0; k < n; k++)
                        push_result(1'b1, fired[k], (k == n - 1), saq_pkg::ST_OK, 4'd0);
                end
            end
        endcase
    endfunction

    task automatic send_cmd(input logic [1:0] cmd, input saq_pkg::alarm_t a,
                            input logic [7:0] nh, input logic [7:0] nm, input logic [7:0] ns);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {a.tag, ns, nm, nh, a[47:0]};
        do @(posedge aclk); while (!s_tready);
        predict_results(cmd, a, nh, nm, ns);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    function automatic void check_result();
        result_t r;
        if (expected_results.size() == 0) begin
            $error("result transaction with nothing outstanding: tdata 0x%0h", m_tdata);
            error_count++;
            return;
        end
        r = expected_results.pop_front();
        check_field("event_valid",    r.event_valid,    m_tuser);
        check_field("event_tag",      r.event_tag,      m_tdata[7:0]);
        check_field("last",           r.last,           m_tlast);
        check_field("status",         r.status,         m_tdata[9:8]);
        check_field("deleted_count",  r.deleted_count,  m_tdata[13:10]);
        check_field("alarm_count",    r.alarm_count,    m_tdata[17:14]);
        check_field("compare_hour",   r.compare_hour,   m_tdata[25:18]);
        check_field("compare_minute", r.compare_minute, m_tdata[33:26]);
        check_field("compare_second", r.compare_second, m_tdata[41:34]);
        check_field("compare_enable", r.compare_enable, m_tdata[42]);
    endfunction

    // result side: check on each transaction, then decide the next ready
    initial begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                check_result();
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_empty_queue();
        send_cmd(saq_pkg::CMD_FIRE,
                 make_alarm(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                 8'h00, 8'h00, 8'h00);
        send_cmd(saq_pkg::CMD_DELETE_TAG,
                 make_alarm(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                 8'h00, 8'h00, 8'h00);
    endtask

    // eight identical datetimes fill the queue, a ninth is dropped, one fire pops all
    task automatic test_full_burst();
        for (int i = 0; i < saq_pkg::DEPTH; i++)
            send_cmd(saq_pkg::CMD_ADD_DATETIME,
                     make_alarm(8'hF0, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99,
                                (i == saq_pkg::DEPTH - 1) ? 8'hFF : 8'(i)),
                     8'h00, 8'h00, 8'h00);
        send_cmd(saq_pkg::CMD_ADD_DATETIME,
                 make_alarm(8'h01, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h42),
                 8'h00, 8'h00, 8'h00);
        send_cmd(saq_pkg::CMD_FIRE,
                 make_alarm(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_add_time();
        send_cmd(saq_pkg::CMD_ADD_TIME,
                 make_alarm(8'h45, 8'h30, 8'h12, 8'h15, 8'h06, 8'h24, 8'h11),
                 8'h08, 8'h00, 8'h00);
        send_cmd(saq_pkg::CMD_ADD_TIME,
                 make_alarm(8'h45, 8'h30, 8'h12, 8'h15, 8'h06, 8'h24, 8'h12),
                 8'h12, 8'h30, 8'h45);
        // day wraps past FF, second 00 is raised to 01
        send_cmd(saq_pkg::CMD_ADD_TIME,
                 make_alarm(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h13),
                 8'hFF, 8'hFF, 8'hFF);
        send_cmd(saq_pkg::CMD_ADD_DATETIME,
                 make_alarm(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                 8'hFF, 8'hFF, 8'hFF);
        send_cmd(saq_pkg::CMD_ADD_DATETIME,
                 make_alarm(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                 8'h00, 8'h00, 8'h00);
    endtask

    // same sort key but different month: ordered after, then a tag delete removes both AA alarms before the fires
    task automatic test_delete_and_fire();
        send_cmd(saq_pkg::CMD_ADD_DATETIME,
                 make_alarm(8'h15, 8'h00, 8'h10, 8'h00, 8'h01, 8'h20, 8'hAA),
                 8'h00, 8'h00, 8'h00);
        send_cmd(saq_pkg::CMD_ADD_DATETIME,
                 make_alarm(8'h15, 8'h00, 8'h10, 8'h00, 8'h02, 8'h20, 8'h55),
                 8'h00, 8'h00, 8'h00);
        send_cmd(saq_pkg::CMD_ADD_DATETIME,
                 make_alarm(8'h15, 8'h00, 8'h10, 8'h00, 8'h01, 8'h20, 8'hAA),
                 8'h00, 8'h00, 8'h00);
        send_cmd(saq_pkg::CMD_DELETE_TAG,
                 make_alarm(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h33),
                 8'h00, 8'h00, 8'h00);
        send_cmd(saq_pkg::CMD_DELETE_TAG,
                 make_alarm(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA),
                 8'h00, 8'h00, 8'h00);
        repeat (2)
            send_cmd(saq_pkg::CMD_FIRE,
                     make_alarm(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                     8'h00, 8'h00, 8'h00);
    endtask

    // small pools of datetimes and tags so that equal times and delete hits are common
    task automatic test_random_mix(input int count, input int add_pct, input int fire_pct);
        saq_pkg::alarm_t a;
        logic [1:0]      cmd;
        logic [7:0]      nh;
        logic [7:0]      nm;
        logic [7:0]      ns;
        int              r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < add_pct)
                cmd = ($urandom_range(0, 2) == 0) ? saq_pkg::CMD_ADD_TIME
                                                  : saq_pkg::CMD_ADD_DATETIME;
            else if (r < add_pct + fire_pct)
                cmd = saq_pkg::CMD_FIRE;
            else
                cmd = saq_pkg::CMD_DELETE_TAG;
            if ($urandom_range(0, 1)) begin
                a = dt_pool[$urandom_range(0, 3)];
                if ($urandom_range(0, 3) == 0) a.month = 8'($urandom);
                if ($urandom_range(0, 3) == 0) a.year = 8'($urandom);
            end else begin
                a = 56'({$urandom, $urandom});
            end
            a.tag = ($urandom_range(0, 9) < 7) ? tag_pool[$urandom_range(0, 3)] : 8'($urandom);
            if ($urandom_range(0, 2) == 0)
                {nh, nm, ns} = {a.hour, a.minute, a.second};
            else
                {nh, nm, ns} = 24'($urandom);
            if ($urandom_range(0, 15) == 0)
                dt_pool[$urandom_range(0, 3)] = 56'({$urandom, $urandom});
            send_cmd(cmd, a, nh, nm, ns);
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        gaps_on     = 1'b1;
        for (int i = 0; i < 4; i++)
            dt_pool[i] = 56'({$urandom, $urandom});
        tag_pool[0] = 8'h00;
        tag_pool[1] = 8'hFF;
        tag_pool[2] = 8'h5A;
        tag_pool[3] = 8'($urandom);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_queue();
        test_full_burst();
        test_add_time();
        test_delete_and_fire();
        test_random_mix(130, 60, 25);
        gaps_on = 1'b0;
        test_random_mix(100, 45, 35);
        gaps_on = 1'b1;
        test_random_mix(130, 35, 50);

        s_tvalid <= 1'b0;
        gaps_on = 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
